[src/proportional_text_glyph_placer_defines.svh]
// Assertion macros shared by the glyph placer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PROPORTIONAL_TEXT_GLYPH_PLACER_DEFINES_SVH
`define PROPORTIONAL_TEXT_GLYPH_PLACER_DEFINES_SVH

// General property, checked on every rising clock edge outside reset.
`define PTGP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication, checked outside reset.
`define PTGP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[src/ptgp_pkg.sv]
// Shared types, codes and constants of the proportional text glyph placer.
// Depends on nothing; used by every module of the block.
package ptgp_pkg;

  localparam int unsigned GLYPH_COUNT_DEF = 94;
  localparam int unsigned PEN_WIDTH_DEF   = 24;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [7:0]  CHAR_NUL     = 8'd0;
  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_SPACE   = 8'd32;
  localparam logic [7:0]  FIRST_GLYPH  = 8'd33;
  localparam logic [7:0]  LAST_GLYPH   = 8'd126;
  localparam logic [16:0] Q16_ONE      = 17'h10000;
  localparam int unsigned TO12_SCALE   = 4095;

  // Configuration reset values.
  localparam logic [16:0] START_X_RST        = 17'd0;
  localparam logic [16:0] START_Y_RST        = 17'd65536;
  localparam logic [15:0] LINE_SPACING_RST   = 16'd0;
  localparam logic [15:0] LETTER_SPACING_RST = 16'd0;
  localparam logic [23:0] PIXEL_SIZE_RST     = 24'd16384;
  localparam logic [7:0]  FONT_SIZE_RST      = 8'd16;
  localparam logic [23:0] TEXT_COLOUR_RST    = 24'hFFFFFF;

  typedef enum logic [2:0] {
    CFG_START_X        = 3'd0,
    CFG_START_Y        = 3'd1,
    CFG_LINE_SPACING   = 3'd2,
    CFG_LETTER_SPACING = 3'd3,
    CFG_PIXEL_SIZE     = 3'd4,
    CFG_FONT_SIZE      = 3'd5,
    CFG_TEXT_COLOUR    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_MOVED     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_OFFSCREEN = 3'd3,
    ST_LOADED    = 3'd4,
    ST_STOPPED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    KIND_WIDTH,
    KIND_STOP,
    KIND_NEWLINE,
    KIND_SPACE,
    KIND_INVALID,
    KIND_GLYPH
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    kind_e      kind;
    logic       first;
    logic [6:0] glyph_idx;
    logic [6:0] width_index;
    logic [7:0] width_value;
  } item_t;

  typedef struct packed {
    logic [16:0] start_x;
    logic [16:0] start_y;
    logic [15:0] line_spacing;
    logic [15:0] letter_spacing;
    logic [23:0] pixel_size;
    logic [7:0]  font_size;
    logic [23:0] text_colour;
  } cfg_t;

  // floor(q * 4095 / 65536), for a position of at most 1.0 in Q16.
  function automatic logic [11:0] to_12bit(input logic [16:0] q);
    logic [28:0] p;
    p = 29'(q) * 29'(TO12_SCALE);
    return p[27:16];
  endfunction

endpackage

[src/ptgp_front.sv]
// Input stage: accepts transactions and classifies each character.
// Depends on ptgp_pkg.
module ptgp_front #(
  parameter int unsigned GLYPH_COUNT = ptgp_pkg::GLYPH_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic              first_i,
  input  logic [7:0]        char_code_i,
  input  logic [6:0]        width_index_i,
  input  logic [7:0]        width_value_i,
  output logic              item_valid_o,
  input  logic              item_ready_i,
  output ptgp_pkg::item_t   item_o
);

  localparam logic [8:0] GlyphLimit = 9'(GLYPH_COUNT);

  logic            fr_valid_q, fr_valid_d;
  ptgp_pkg::item_t fr_item_q, cls_item;
  logic [7:0]      gi;
  logic            accept, push;

  always_comb begin
    gi                   = char_code_i - ptgp_pkg::FIRST_GLYPH;
    cls_item.first       = first_i;
    cls_item.glyph_idx   = gi[6:0];
    cls_item.width_index = width_index_i;
    cls_item.width_value = width_value_i;
    if (opcode_i) begin
      cls_item.kind = ptgp_pkg::KIND_WIDTH;
    end else if (char_code_i == ptgp_pkg::CHAR_NUL) begin
      cls_item.kind = ptgp_pkg::KIND_STOP;
    end else if (char_code_i == ptgp_pkg::CHAR_NEWLINE) begin
      cls_item.kind = ptgp_pkg::KIND_NEWLINE;
    end else if (char_code_i == ptgp_pkg::CHAR_SPACE) begin
      cls_item.kind = ptgp_pkg::KIND_SPACE;
    end else if (char_code_i >= ptgp_pkg::FIRST_GLYPH && char_code_i <= ptgp_pkg::LAST_GLYPH
                 && {1'b0, gi} < GlyphLimit) begin
      cls_item.kind = ptgp_pkg::KIND_GLYPH;
    end else begin
      cls_item.kind = ptgp_pkg::KIND_INVALID;
    end
  end

  assign push         = fr_valid_q && item_ready_i;
  assign in_ready_o   = !fr_valid_q || item_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign fr_valid_d   = accept || (fr_valid_q && !push);
  assign item_valid_o = fr_valid_q;
  assign item_o       = fr_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_item_q <= cls_item;
    end
  end

endmodule

[src/ptgp_queue.sv]
// Short queue of classified items between the front and back stages.
// Depends on ptgp_pkg and the assertion macro header.
`include "proportional_text_glyph_placer_defines.svh"
module ptgp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptgp_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ptgp_pkg::item_t head_o
);

  localparam int unsigned Depth = ptgp_pkg::QUEUE_DEPTH;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  ptgp_pkg::item_t  entries_q [Depth];
  logic [AddrW:0]   wptr_q, wptr_d, rptr_q, rptr_d;

  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[AddrW] != rptr_q[AddrW]) &&
                   (wptr_q[AddrW-1:0] == rptr_q[AddrW-1:0]);
  assign head_o  = entries_q[rptr_q[AddrW-1:0]];
  assign wptr_d  = push_i ? wptr_q + 1'b1 : wptr_q;
  assign rptr_d  = pop_i ? rptr_q + 1'b1 : rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q[AddrW-1:0]] <= push_item_i;
    end
  end

  `PTGP_ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `PTGP_ASSERT_IMPLIES(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `PTGP_ASSERT(a_ptr_span, clk_i, rst_ni, (wptr_q - rptr_q) <= (AddrW+1)'(Depth), "queue count exceeds depth")

endmodule

[src/ptgp_back.sv]
// Execution stage: glyph width table, advance multiplies, pen state and result register.
// Depends on ptgp_pkg and the assertion macro header.
`include "proportional_text_glyph_placer_defines.svh"
module ptgp_back #(
  parameter int unsigned GLYPH_COUNT = ptgp_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned PEN_WIDTH   = ptgp_pkg::PEN_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptgp_pkg::cfg_t  cfg_i,
  input  logic            empty_i,
  input  ptgp_pkg::item_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output logic [31:0]     place_word_o,
  output logic [31:0]     style_word_o
);

  localparam int unsigned IdxW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int unsigned AdvW = 29;
  localparam int unsigned SumW = ((PEN_WIDTH > AdvW) ? PEN_WIDTH : AdvW) + 1;
  localparam logic [PEN_WIDTH-1:0] PenMax = {PEN_WIDTH{1'b1}};
  localparam logic [7:0] GlyphLimit = 8'(GLYPH_COUNT);

  ptgp_pkg::bk_state_e  state_q, state_d;
  ptgp_pkg::item_t      cur_q;
  logic                 fire, rd_en, tbl_we;
  logic [IdxW-1:0]      rd_idx, wr_idx;

  logic [7:0]           tbl_mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] tbl_vld_q;
  logic [7:0]           rd_data_q;
  logic                 rd_vld_q;

  logic [31:0]          prod1_q, prod1_d;
  logic [23:0]          small_q, small_d;
  logic [40:0]          prod2_q, prod2_d;
  logic [32:0]          sum33;
  logic [7:0]           w_eff;

  logic [PEN_WIDTH-1:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic                 stopped_q, stopped_d;
  logic [SumW-1:0]      glyph_sum, space_sum, drop_ext;
  logic                 offscreen;

  ptgp_pkg::status_e    res_status;
  logic [31:0]          res_place, res_style;
  logic                 out_valid_q;
  logic [2:0]           out_status_q;
  logic [31:0]          out_place_q, out_style_q;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptgp_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = ptgp_pkg::BK_MUL1;
        end
      end
      ptgp_pkg::BK_MUL1: state_d = ptgp_pkg::BK_MUL2;
      ptgp_pkg::BK_MUL2: state_d = ptgp_pkg::BK_DONE;
      ptgp_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ptgp_pkg::BK_IDLE;
        end
      end
      default: state_d = ptgp_pkg::BK_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    pop_o = 1'b0;
    rd_en = 1'b0;
    fire  = 1'b0;
    case (state_q)
      ptgp_pkg::BK_IDLE: begin
        pop_o = !empty_i;
        rd_en = !empty_i && (head_i.kind == ptgp_pkg::KIND_GLYPH);
      end
      ptgp_pkg::BK_DONE: fire = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign rd_idx = head_i.glyph_idx[IdxW-1:0];
  assign wr_idx = cur_q.width_index[IdxW-1:0];

  // Multiply chain: width times pixel size, then font size times the sum.
  always_comb begin
    w_eff   = rd_vld_q ? rd_data_q : 8'd0;
    prod1_d = 32'(w_eff) * 32'(cfg_i.pixel_size);
    small_d = 24'((cur_q.kind == ptgp_pkg::KIND_NEWLINE) ? cfg_i.line_spacing
                                                          : cfg_i.letter_spacing)
              * 24'(cfg_i.font_size);
    sum33   = 33'(prod1_q) + {9'd0, cfg_i.letter_spacing, 8'd0};
    prod2_d = 41'(sum33) * 41'(cfg_i.font_size);
  end

  // Result and pen update.
  always_comb begin
    glyph_sum = SumW'(pen_x_q) + SumW'(prod2_q[40:12]);
    space_sum = SumW'(pen_x_q) + SumW'(small_q[23:2]);
    drop_ext  = SumW'(small_q[23:4]);
    offscreen = (SumW'(pen_x_q) > SumW'(ptgp_pkg::Q16_ONE)) ||
                (SumW'(pen_y_q) > SumW'(ptgp_pkg::Q16_ONE));
    pen_x_d    = pen_x_q;
    pen_y_d    = pen_y_q;
    stopped_d  = stopped_q;
    res_place  = '0;
    res_style  = '0;
    tbl_we     = 1'b0;
    res_status = ptgp_pkg::ST_LOADED;

    if (cur_q.kind == ptgp_pkg::KIND_WIDTH) begin
      res_status = ptgp_pkg::ST_LOADED;
      tbl_we     = fire && ({1'b0, cur_q.width_index} < GlyphLimit);
    end else if (stopped_q || cur_q.kind == ptgp_pkg::KIND_STOP) begin
      res_status = ptgp_pkg::ST_STOPPED;
      if (fire) begin
        stopped_d = 1'b1;
      end
    end else if (cur_q.kind == ptgp_pkg::KIND_NEWLINE) begin
      res_status = ptgp_pkg::ST_MOVED;
      if (fire) begin
        pen_x_d = PEN_WIDTH'(cfg_i.start_x);
        // A drop below the bottom edge parks the pen where later glyphs are off-screen.
        pen_y_d = (drop_ext > SumW'(pen_y_q)) ? PenMax : pen_y_q - drop_ext[PEN_WIDTH-1:0];
      end
    end else if (cur_q.kind == ptgp_pkg::KIND_SPACE) begin
      res_status = ptgp_pkg::ST_MOVED;
      if (fire) begin
        pen_x_d = (space_sum > SumW'(PenMax)) ? PenMax : space_sum[PEN_WIDTH-1:0];
      end
    end else if (cur_q.kind == ptgp_pkg::KIND_GLYPH) begin
      if (offscreen) begin
        res_status = ptgp_pkg::ST_OFFSCREEN;
      end else begin
        res_status = ptgp_pkg::ST_PLACED;
        res_place  = {1'b0, cur_q.glyph_idx,
                      ptgp_pkg::to_12bit(pen_y_q[16:0]),
                      ptgp_pkg::to_12bit(pen_x_q[16:0])};
        res_style  = {cfg_i.font_size, cfg_i.text_colour};
        if (fire) begin
          pen_x_d = (glyph_sum > SumW'(PenMax)) ? PenMax : glyph_sum[PEN_WIDTH-1:0];
        end
      end
    end else begin
      res_status = ptgp_pkg::ST_INVALID;
    end

    // The first flag reloads the pen as the item leaves the queue.
    if (pop_o && head_i.kind != ptgp_pkg::KIND_WIDTH && head_i.first) begin
      pen_x_d   = PEN_WIDTH'(cfg_i.start_x);
      pen_y_d   = PEN_WIDTH'(cfg_i.start_y);
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptgp_pkg::BK_IDLE;
      pen_x_q     <= PEN_WIDTH'(ptgp_pkg::START_X_RST);
      pen_y_q     <= PEN_WIDTH'(ptgp_pkg::START_Y_RST);
      stopped_q   <= 1'b0;
      tbl_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      stopped_q   <= stopped_d;
      out_valid_q <= fire || (out_valid_q && !out_ready_i);
      if (tbl_we) begin
        tbl_vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= tbl_vld_q[rd_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[wr_idx] <= cur_q.width_value;
    end
    if (rd_en) begin
      rd_data_q <= tbl_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (state_q == ptgp_pkg::BK_MUL1) begin
      prod1_q <= prod1_d;
      small_q <= small_d;
    end
    if (state_q == ptgp_pkg::BK_MUL2) begin
      prod2_q <= prod2_d;
    end
    if (fire) begin
      out_status_q <= res_status;
      out_place_q  <= res_place;
      out_style_q  <= res_style;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign place_word_o = out_place_q;
  assign style_word_o = out_style_q;

  `PTGP_ASSERT_IMPLIES(a_words_zero, clk_i, rst_ni, out_valid_q && out_status_q != ptgp_pkg::ST_PLACED, out_place_q == '0 && out_style_q == '0, "result words set without a placed glyph")
  `PTGP_ASSERT(a_stop_sticks, clk_i, rst_ni, fire && cur_q.kind == ptgp_pkg::KIND_STOP |=> stopped_q, "NUL did not stop the string")
  `PTGP_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ptgp_pkg::BK_DONE, "result appeared outside the final step")

endmodule

[src/proportional_text_glyph_placer.sv]
// Top level of the proportional text glyph placer: ports, configuration registers
// and the front, queue and back stages. Depends on ptgp_pkg and the ptgp_* modules.
//
// Usage: each slave-side transaction carries one character to place or one glyph
// width to load (selected by tuser). Each is answered by exactly one master-side
// transaction: a status code on tuser and, for a placed glyph, a packed position
// word and a style word on tdata. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle; indexes beyond the list are
// ignored.
// The back stage handles one item at a time: it reads the glyph width table, runs
// two dependent multiplies and then updates the pen, and it pops the next item only
// once the result register has taken the current result. The front stage and a
// two-entry queue keep taking input while the back stage works or the result
// register waits on a stalled receiver; a stalled receiver holds the result and
// eventually backs up to s_axis_tready_o.
// Reset clears all pen, stop and table state at once (no clearing pass): the pen
// returns to the reset start position and every glyph width reads as zero.
module proportional_text_glyph_placer #(
  parameter int unsigned GLYPH_COUNT = ptgp_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned PEN_WIDTH   = ptgp_pkg::PEN_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // first, char_code, width_index, width_value
  input  logic [0:0]  s_axis_tuser_i,   // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // place_word, style_word
  output logic [2:0]  m_axis_tuser_o,   // status
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  ptgp_pkg::cfg_t  cfg_q;
  ptgp_pkg::item_t fr_item, head_item;
  logic            fr_valid, q_full, q_empty, q_pop;
  logic [31:0]     place_word, style_word;

  // Configuration registers; a write takes effect at the next edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x        <= ptgp_pkg::START_X_RST;
      cfg_q.start_y        <= ptgp_pkg::START_Y_RST;
      cfg_q.line_spacing   <= ptgp_pkg::LINE_SPACING_RST;
      cfg_q.letter_spacing <= ptgp_pkg::LETTER_SPACING_RST;
      cfg_q.pixel_size     <= ptgp_pkg::PIXEL_SIZE_RST;
      cfg_q.font_size      <= ptgp_pkg::FONT_SIZE_RST;
      cfg_q.text_colour    <= ptgp_pkg::TEXT_COLOUR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptgp_pkg::CFG_START_X:        cfg_q.start_x        <= cfg_data_i[16:0];
        ptgp_pkg::CFG_START_Y:        cfg_q.start_y        <= cfg_data_i[16:0];
        ptgp_pkg::CFG_LINE_SPACING:   cfg_q.line_spacing   <= cfg_data_i[15:0];
        ptgp_pkg::CFG_LETTER_SPACING: cfg_q.letter_spacing <= cfg_data_i[15:0];
        ptgp_pkg::CFG_PIXEL_SIZE:     cfg_q.pixel_size     <= cfg_data_i;
        ptgp_pkg::CFG_FONT_SIZE:      cfg_q.font_size      <= cfg_data_i[7:0];
        ptgp_pkg::CFG_TEXT_COLOUR:    cfg_q.text_colour    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: register the transaction and classify the character.
  ptgp_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .opcode_i      (s_axis_tuser_i[0]),
    .first_i       (s_axis_tdata_i[0]),
    .char_code_i   (s_axis_tdata_i[8:1]),
    .width_index_i (s_axis_tdata_i[15:9]),
    .width_value_i (s_axis_tdata_i[23:16]),
    .item_valid_o  (fr_valid),
    .item_ready_i  (!q_full),
    .item_o        (fr_item)
  );

  // Queue decoupling the front from the back.
  ptgp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_valid && !q_full),
    .push_item_i (fr_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  // Back: table, multiplies, pen state and the result register.
  ptgp_back #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .PEN_WIDTH   (PEN_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (q_empty),
    .head_i       (head_item),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (m_axis_tuser_o),
    .place_word_o (place_word),
    .style_word_o (style_word)
  );

  assign m_axis_tdata_o = {style_word, place_word};

endmodule

[tb/testbench.sv]
// Self-checking testbench for proportional_text_glyph_placer: streams characters and
// glyph width loads, predicts every result in SystemVerilog and compares per field.
// Depends on ptgp_pkg and the RTL of the block; nothing else.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ptgp_pkg::*;

  // Opcodes carried on s_axis_tuser_i.
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_WIDTH = 1'b1;

  // A register index past the end of the list; the block must ignore it.
  localparam logic [2:0] CFG_SPARE_IDX = 3'd7;

  localparam longint unsigned PEN_MAX = (64'd1 << PEN_WIDTH_DEF) - 64'd1;

  // Margin waited after the last result has come out, when draining.
  localparam int DRAIN_SLACK    = 10;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    status_e     status;
    logic [31:0] place;
    logic [31:0] style;
  } glyph_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;   // first, char_code, width_index, width_value
  logic [0:0]  s_axis_tuser_i = '0;   // opcode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // place_word, style_word
  logic [2:0]  m_axis_tuser_o;        // status
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  proportional_text_glyph_placer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Layout state as the block should hold it: configuration, pen, width table, stop flag.
  cfg_t            layout_cfg;
  longint unsigned x_pos;
  longint unsigned y_pos;
  logic [7:0]      glyph_w [GLYPH_COUNT_DEF];
  logic            text_halted;

  // Results owed by the block, oldest first.
  glyph_result_t   pending_results [$];

  int error_count = 0;
  int idle_cycles = 0;
  // Percent of cycles in which the sender holds back and the receiver stalls.
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Layout predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned pen_add(longint unsigned a, longint unsigned b);
    return (a + b > PEN_MAX) ? PEN_MAX : a + b;
  endfunction

  // Q16 screen fraction to the 12-bit coordinate of the output word (floor of q*4095).
  function automatic logic [11:0] screen_12(longint unsigned q);
    longint unsigned p;
    p = (q * 64'd4095) >> 16;
    return p[11:0];
  endfunction

  // Updates the layout state for one accepted transaction and returns its result.
  function automatic glyph_result_t place_character(logic op, logic first, logic [7:0] code,
                                                    logic [6:0] widx, logic [7:0] wval);
    glyph_result_t   r;
    longint unsigned drop;
    longint unsigned adv;
    longint unsigned font;
    longint unsigned gi;
    r.status = ST_PLACED;
    r.place  = '0;
    r.style  = '0;
    font     = longint'(layout_cfg.font_size);

    if (op == OP_WIDTH) begin
      // Width loads ignore the first flag and the stop flag alike.
      if (widx < GLYPH_COUNT_DEF) glyph_w[widx] = wval;
      r.status = ST_LOADED;
      return r;
    end

    if (first) begin
      x_pos       = longint'(layout_cfg.start_x);
      y_pos       = longint'(layout_cfg.start_y);
      text_halted = 1'b0;
    end

    if (text_halted || code == CHAR_NUL) begin
      text_halted = 1'b1;
      r.status    = ST_STOPPED;
      return r;
    end

    if (code == CHAR_NEWLINE) begin
      drop  = (longint'(layout_cfg.line_spacing) * font) >> 4;
      x_pos = longint'(layout_cfg.start_x);
      // Falling past the bottom parks Y at the pen maximum, so it reads as off-screen.
      y_pos = (drop > y_pos) ? PEN_MAX : y_pos - drop;
      r.status = ST_MOVED;
      return r;
    end

    if (code == CHAR_SPACE) begin
      x_pos    = pen_add(x_pos, (longint'(layout_cfg.letter_spacing) * font) >> 2);
      r.status = ST_MOVED;
      return r;
    end

    if (code < FIRST_GLYPH || code > LAST_GLYPH || code - FIRST_GLYPH >= GLYPH_COUNT_DEF) begin
      r.status = ST_INVALID;
      return r;
    end

    if (x_pos > Q16_ONE || y_pos > Q16_ONE) begin
      r.status = ST_OFFSCREEN;
      return r;
    end

    gi  = longint'(code - FIRST_GLYPH);
    adv = (font * (longint'(glyph_w[gi]) * longint'(layout_cfg.pixel_size)
                   + (longint'(layout_cfg.letter_spacing) << 8))) >> 12;
    r.place = {1'b0, gi[6:0], screen_12(y_pos), screen_12(x_pos)};
    r.style = {layout_cfg.font_size, layout_cfg.text_colour};
    x_pos   = pen_add(x_pos, adv);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch in %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  // Every master-side transaction is matched against the oldest pending result.
  always @(posedge clk_i) begin : check_results
    glyph_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transaction", m_axis_tdata_o[31:0],
                        32'(m_axis_tuser_o));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o !== want.status)
          report_mismatch("status", 32'(m_axis_tuser_o), 32'(want.status));
        if (m_axis_tdata_o[31:0] !== want.place)
          report_mismatch("place word", m_axis_tdata_o[31:0], want.place);
        if (m_axis_tdata_o[63:32] !== want.style)
          report_mismatch("style word", m_axis_tdata_o[63:32], want.style);
      end
    end
  end

  // The watchdog is reset by any transaction on either stream.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver stalls at random, at the rate set for the current phase.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one item and waits for its transaction. tvalid stays high on return so
  // that back-to-back items never lower and raise it within one time step.
  task automatic send_item(input logic op, input logic first, input logic [7:0] code,
                           input logic [6:0] widx, input logic [7:0] wval);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {wval, widx, code, first};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(place_character(op, first, code, widx, wval));
  endtask

  task automatic place_char(input logic first, input logic [7:0] code);
    send_item(OP_PLACE, first, code, 7'($urandom), 8'($urandom));
  endtask

  task automatic load_width(input logic [6:0] widx, input logic [7:0] wval);
    send_item(OP_WIDTH, 1'($urandom), 8'($urandom), widx, wval);
  endtask

  // Holds the sender back until every pending result has come out of the block.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_START_X:        layout_cfg.start_x        = data[16:0];
      CFG_START_Y:        layout_cfg.start_y        = data[16:0];
      CFG_LINE_SPACING:   layout_cfg.line_spacing   = data[15:0];
      CFG_LETTER_SPACING: layout_cfg.letter_spacing = data[15:0];
      CFG_PIXEL_SIZE:     layout_cfg.pixel_size     = data;
      CFG_FONT_SIZE:      layout_cfg.font_size      = data[7:0];
      CFG_TEXT_COLOUR:    layout_cfg.text_colour    = data;
      default: ;
    endcase
  endtask

  // Writes the whole register set, plus a stray write to an unused index, once idle.
  task automatic apply_layout(input cfg_t c);
    wait_results_drained();
    write_reg(CFG_START_X,        24'(c.start_x));
    write_reg(CFG_START_Y,        24'(c.start_y));
    write_reg(CFG_LINE_SPACING,   24'(c.line_spacing));
    write_reg(CFG_LETTER_SPACING, 24'(c.letter_spacing));
    write_reg(CFG_PIXEL_SIZE,     c.pixel_size);
    write_reg(CFG_FONT_SIZE,      24'(c.font_size));
    write_reg(CFG_TEXT_COLOUR,    c.text_colour);
    write_reg(CFG_SPARE_IDX,      24'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Table loads at both ends of the slot range and past it; out-of-range slots are dropped.
  task automatic test_width_table();
    load_width(7'd0, 8'hFF);
    load_width(7'd93, 8'd1);
    load_width(7'd94, 8'h00);
    load_width(7'd127, 8'hFF);
  endtask

  // Large spacings and the largest font drive the pen into saturation and below the
  // bottom edge; then the stop flag, invalid codes and the first flag are exercised.
  task automatic test_special_cases();
    cfg_t c;
    c.start_x        = 17'd0;
    c.start_y        = 17'd65536;
    c.line_spacing   = 16'hFFFF;
    c.letter_spacing = 16'hFFFF;
    c.pixel_size     = PIXEL_SIZE_RST;
    c.font_size      = 8'hFF;
    c.text_colour    = 24'h5A3CE1;
    apply_layout(c);

    place_char(1'b1, FIRST_GLYPH);          // '!' at the top left corner
    place_char(1'b0, LAST_GLYPH);           // '~', the last glyph slot
    repeat (4) place_char(1'b0, CHAR_SPACE); // X saturates at the pen maximum
    place_char(1'b0, 8'h41);                // off-screen in X
    place_char(1'b0, CHAR_NEWLINE);         // the drop exceeds Y, so Y parks
    place_char(1'b0, 8'h42);                // off-screen in Y
    place_char(1'b0, 8'd1);                 // control and high codes are invalid
    place_char(1'b0, 8'd31);
    place_char(1'b0, 8'd127);
    place_char(1'b0, 8'hFF);
    place_char(1'b0, CHAR_NUL);             // stops the string
    place_char(1'b0, 8'h43);                // still stopped
    place_char(1'b0, CHAR_NEWLINE);         // still stopped
    load_width(7'd34, 8'h80);               // loads go through while stopped
    place_char(1'b1, 8'h44);                // first flag restarts the string
    place_char(1'b1, CHAR_NUL);             // first flag with NUL stops at once
  endtask

  // Mostly well-formed strings with random content; a few broken items and noise.
  task automatic test_random_text(input cfg_t c, input int count);
    int         pick;
    int         left_in_string;
    logic       first;
    logic [7:0] code;
    apply_layout(c);
    left_in_string = 0;
    for (int n = 0; n < count; n++) begin
      if (left_in_string == 0) begin
        left_in_string = $urandom_range(24, 3);
        first = 1'b1;
      end else begin
        first = ($urandom_range(99) < 4);
      end
      left_in_string--;
      pick = $urandom_range(99);
      if (pick < 62) begin
        place_char(first, 8'($urandom_range(LAST_GLYPH, FIRST_GLYPH)));
      end else if (pick < 72) begin
        place_char(first, CHAR_SPACE);
      end else if (pick < 78) begin
        place_char(first, CHAR_NEWLINE);
      end else if (pick < 81) begin
        place_char(first, CHAR_NUL);
      end else if (pick < 87) begin
        code = $urandom_range(1) ? 8'($urandom_range(255, 127)) : 8'($urandom_range(31, 1));
        if (code == CHAR_NEWLINE) code = code + 8'd1;
        place_char(first, code);
      end else if (pick < 95) begin
        load_width(($urandom_range(99) < 90) ? 7'($urandom_range(GLYPH_COUNT_DEF - 1))
                                             : 7'($urandom_range(127, GLYPH_COUNT_DEF)),
                   8'($urandom));
      end else begin
        send_item(1'($urandom), 1'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
      end
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(99) < 2) wait_results_drained();
    end
  endtask

  function automatic cfg_t random_layout();
    cfg_t c;
    c.start_x        = 17'($urandom_range(16384));
    c.start_y        = 17'($urandom_range(65536, 32768));
    c.line_spacing   = 16'($urandom_range(8191));
    c.letter_spacing = 16'($urandom_range(1023));
    c.pixel_size     = 24'($urandom_range(16384));
    c.font_size      = 8'($urandom_range(32, 1));
    c.text_colour    = 24'($urandom);
    return c;
  endfunction

  // Register extremes: every field at its top, every field at its bottom, then a mix.
  function automatic cfg_t extreme_layout(input int which);
    cfg_t c;
    case (which)
      0: c = '{17'd65536, 17'd65536, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF, 24'hFFFFFF};
      1: c = '{17'd0, 17'd0, 16'h0000, 16'h0000, 24'h000000, 8'h00, 24'h000000};
      default: c = '{17'd65536, 17'd0, 16'h0000, 16'hFFFF, 24'hFFFFFF, 8'hFF, 24'h000000};
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // State of the block right after reset.
    layout_cfg.start_x        = START_X_RST;
    layout_cfg.start_y        = START_Y_RST;
    layout_cfg.line_spacing   = LINE_SPACING_RST;
    layout_cfg.letter_spacing = LETTER_SPACING_RST;
    layout_cfg.pixel_size     = PIXEL_SIZE_RST;
    layout_cfg.font_size      = FONT_SIZE_RST;
    layout_cfg.text_colour    = TEXT_COLOUR_RST;
    x_pos       = longint'(START_X_RST);
    y_pos       = longint'(START_Y_RST);
    text_halted = 1'b0;
    foreach (glyph_w[i]) glyph_w[i] = 8'h00;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part runs with sender and receiver both at full rate.
    test_width_table();
    test_special_cases();

    // Three phases: a slow receiver, then a slow sender, then neither holding back.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 15;
          snk_idle_pct = 51;
        end
        1: begin
          src_idle_pct = 51;
          snk_idle_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      test_random_text(random_layout(), 50);
      test_random_text(random_layout(), 50);
      test_random_text(extreme_layout(phase), 30);
    end

    wait_results_drained();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/ptgp_pkg.sv
src/ptgp_front.sv
src/ptgp_queue.sv
src/ptgp_back.sv
src/proportional_text_glyph_placer.sv
tb/testbench.sv
